>>> design/olt_pkg.sv
// types and codes shared by the order lifecycle table
// no dependencies; imported by olt_cell and order_lifecycle_table
package olt_pkg;

    // slot numbers are carried at the width of the largest table
    localparam int IDX_W = 16;

    localparam logic [2:0] CMD_ENTER   = 3'd0;
    localparam logic [2:0] CMD_REPLACE = 3'd1;
    localparam logic [2:0] CMD_CANCEL  = 3'd2;
    localparam logic [2:0] CMD_EXECUTE = 3'd3;
    localparam logic [2:0] CMD_CLEAR   = 3'd4;

    localparam logic [2:0] ST_ACCEPTED      = 3'd0;
    localparam logic [2:0] ST_REPLACED      = 3'd1;
    localparam logic [2:0] ST_CANCELED      = 3'd2;
    localparam logic [2:0] ST_PART_CANCELED = 3'd3;
    localparam logic [2:0] ST_FILLED        = 3'd4;
    localparam logic [2:0] ST_PART_FILLED   = 3'd5;
    localparam logic [2:0] ST_REJECTED      = 3'd6;
    localparam logic [2:0] ST_CLEARED       = 3'd7;

    localparam logic [3:0] RR_NONE      = 4'd0;
    localparam logic [3:0] RR_QUANTITY  = 4'd1;
    localparam logic [3:0] RR_PRICE     = 4'd2;
    localparam logic [3:0] RR_FIELDS    = 4'd3;
    localparam logic [3:0] RR_DUPLICATE = 4'd4;
    localparam logic [3:0] RR_STALE     = 4'd5;
    localparam logic [3:0] RR_UNKNOWN   = 4'd6;
    localparam logic [3:0] RR_OVERFILL  = 4'd7;
    localparam logic [3:0] RR_FULL      = 4'd8;

    localparam logic REG_MAX_QUANTITY = 1'b0;
    localparam logic REG_MAX_PRICE    = 1'b1;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] user_ref;
        logic [31:0] orig_user_ref;
        logic [31:0] quantity;
        logic [31:0] price;
        logic        fields_ok;
    } order_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  reason;
        logic [31:0] result_ref;
        logic [31:0] previous_ref;
        logic [31:0] dec_qty;
        logic [31:0] leaves_qty;
        logic [8:0]  live_count;
        logic [31:0] highest_ref;
    } result_t;

    // search word walking down the chain of cells
    typedef struct packed {
        logic             active;
        logic [31:0]      user_ref;
        logic [31:0]      orig_ref;
        logic             hit_user;
        logic [IDX_W-1:0] slot_user;
        logic [31:0]      leaves_user;
        logic             hit_orig;
        logic [IDX_W-1:0] slot_orig;
        logic [31:0]      leaves_orig;
        logic             has_free;
        logic [IDX_W-1:0] slot_free;
    } probe_t;

    // update broadcast to every cell
    typedef struct packed {
        logic             en;
        logic             clr_all;
        logic [IDX_W-1:0] slot;
        logic             valid;
        logic [31:0]      ref_val;
        logic [31:0]      leaves;
    } update_t;

endpackage

>>> design/order_lifecycle_table.sv
// order lifecycle table top level: sequencer, limits and chain of slot cells
// depends on olt_pkg and olt_cell
//
// channel   | ports                          | handshake
// ----------+--------------------------------+------------------------------
// command   | start, busy, order             | taken when start && !busy
// result    | done, result                   | one cycle, no back-pressure
// config    | cfg_we, cfg_index, cfg_wdata   | written when cfg_we is high
//
// a command runs in steps: the probe word walks the chain one
// slot per cycle, then the decision and the slot update happen in one cycle
// and the result word shows on the next cycle with busy already low
// reset clears all slots, the counters and loads the default limits
// the receiver cannot stall, so done is a single-cycle strobe
module order_lifecycle_table #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  olt_pkg::order_t  order,
    output logic             done,
    output olt_pkg::result_t result,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [31:0]      cfg_wdata
);
    import olt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] max_qty_reg, max_price_reg;
    logic [31:0] highest_reg, highest_next;
    logic [8:0]  live_reg, live_next;
    order_t      item_reg;
    probe_t      inj_reg;
    logic        inj_active_reg;
    probe_t      inj_word;
    result_t     result_reg, result_next;
    logic        done_reg;
    update_t     upd;
    probe_t      chain [0:TABLE_ENTRIES];

    logic        qty_ok, price_ok, finish;
    logic [31:0] rest;

    // injected probe word with the reset marker
    always_comb
    begin
        inj_word        = inj_reg;
        inj_word.active = inj_active_reg;
    end

    assign chain[0] = inj_word;
    assign finish   = chain[TABLE_ENTRIES].active;

    // row of slot cells
    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++)
        begin : g_cell
            olt_cell #(.SLOT(16'(gi))) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .probe_in  (chain[gi]),
                .upd       (upd),
                .probe_out (chain[gi+1])
            );
        end
    endgenerate

    // decision on the finished probe word
    always_comb
    begin
        probe_t t;
        t            = chain[TABLE_ENTRIES];
        qty_ok       = item_reg.quantity != 32'd0 && item_reg.quantity <= max_qty_reg;
        price_ok     = item_reg.price != 32'd0 && item_reg.price <= max_price_reg;
        rest         = t.leaves_user - item_reg.quantity;
        upd          = '0;
        live_next    = live_reg;
        highest_next = highest_reg;
        result_next  = '0;
        result_next.status     = ST_REJECTED;
        result_next.reason     = RR_FIELDS;
        result_next.result_ref = item_reg.user_ref;
        unique case (item_reg.cmd)
            CMD_ENTER, CMD_REPLACE:
            begin
                if (!qty_ok)
                    result_next.reason = RR_QUANTITY;
                else if (!price_ok)
                    result_next.reason = RR_PRICE;
                else if (!item_reg.fields_ok)
                    result_next.reason = RR_FIELDS;
                else if (item_reg.cmd == CMD_REPLACE && !t.hit_orig)
                    result_next.reason = RR_UNKNOWN;
                else if (t.hit_user)
                    result_next.reason = RR_DUPLICATE;
                else if (item_reg.user_ref <= highest_reg)
                    result_next.reason = RR_STALE;
                else if (item_reg.cmd == CMD_ENTER && !t.has_free)
                    result_next.reason = RR_FULL;
                else
                begin
                    upd.en      = 1'b1;
                    upd.valid   = 1'b1;
                    upd.ref_val = item_reg.user_ref;
                    upd.leaves  = item_reg.quantity;
                    highest_next = item_reg.user_ref;
                    result_next.reason     = RR_NONE;
                    result_next.leaves_qty = item_reg.quantity;
                    if (item_reg.cmd == CMD_ENTER)
                    begin
                        upd.slot  = t.slot_free;
                        live_next = live_reg + 9'd1;
                        result_next.status = ST_ACCEPTED;
                    end
                    else
                    begin
                        upd.slot = t.slot_orig;
                        result_next.status       = ST_REPLACED;
                        result_next.previous_ref = item_reg.orig_user_ref;
                        result_next.dec_qty      = t.leaves_orig;
                    end
                end
            end
            CMD_CANCEL:
            begin
                if (!item_reg.fields_ok)
                    result_next.reason = RR_QUANTITY;
                else if (!t.hit_user)
                    result_next.reason = RR_UNKNOWN;
                else
                begin
                    upd.en      = 1'b1;
                    upd.slot    = t.slot_user;
                    upd.ref_val = item_reg.user_ref;
                    result_next.reason = RR_NONE;
                    if (item_reg.quantity == 32'd0 || item_reg.quantity >= t.leaves_user)
                    begin
                        upd.valid  = 1'b0;
                        upd.leaves = t.leaves_user;
                        live_next  = live_reg - 9'd1;
                        result_next.status  = ST_CANCELED;
                        result_next.dec_qty = t.leaves_user;
                    end
                    else
                    begin
                        upd.valid  = 1'b1;
                        upd.leaves = rest;
                        result_next.status     = ST_PART_CANCELED;
                        result_next.dec_qty    = item_reg.quantity;
                        result_next.leaves_qty = rest;
                    end
                end
            end
            CMD_EXECUTE:
            begin
                if (!qty_ok)
                    result_next.reason = RR_QUANTITY;
                else if (!t.hit_user)
                    result_next.reason = RR_UNKNOWN;
                else if (item_reg.quantity > t.leaves_user)
                    result_next.reason = RR_OVERFILL;
                else
                begin
                    upd.en      = 1'b1;
                    upd.slot    = t.slot_user;
                    upd.ref_val = item_reg.user_ref;
                    upd.leaves  = rest;
                    upd.valid   = rest != 32'd0;
                    result_next.reason  = RR_NONE;
                    result_next.dec_qty = item_reg.quantity;
                    if (rest == 32'd0)
                    begin
                        live_next = live_reg - 9'd1;
                        result_next.status = ST_FILLED;
                    end
                    else
                    begin
                        result_next.status     = ST_PART_FILLED;
                        result_next.leaves_qty = rest;
                    end
                end
            end
            CMD_CLEAR:
            begin
                upd.clr_all  = 1'b1;
                live_next    = 9'd0;
                highest_next = 32'd0;
                result_next.status     = ST_CLEARED;
                result_next.reason     = RR_NONE;
                result_next.result_ref = 32'd0;
            end
            default:
            begin
                result_next.reason = RR_FIELDS;
            end
        endcase
        result_next.live_count  = live_next;
        result_next.highest_ref = highest_next;
        if (!finish)
        begin
            upd = '0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_SCAN;
            S_SCAN:  if (finish) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            max_qty_reg    <= 32'd1000000;
            max_price_reg  <= 32'd2000000000;
            highest_reg    <= 32'd0;
            live_reg       <= 9'd0;
            done_reg       <= 1'b0;
            inj_active_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= finish;
            inj_active_reg <= state_reg == S_IDLE && start;
            if (finish)
            begin
                highest_reg <= highest_next;
                live_reg    <= live_next;
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_MAX_QUANTITY)
                    max_qty_reg <= cfg_wdata;
                else if (cfg_index == REG_MAX_PRICE)
                    max_price_reg <= cfg_wdata;
            end
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            item_reg             <= order;
            inj_reg.active       <= 1'b1;
            inj_reg.user_ref     <= order.user_ref;
            inj_reg.orig_ref     <= order.orig_user_ref;
            inj_reg.hit_user     <= 1'b0;
            inj_reg.slot_user    <= '0;
            inj_reg.leaves_user  <= '0;
            inj_reg.hit_orig     <= 1'b0;
            inj_reg.slot_orig    <= '0;
            inj_reg.leaves_orig  <= '0;
            inj_reg.has_free     <= 1'b0;
            inj_reg.slot_free    <= '0;
        end
        if (finish)
        begin
            result_reg <= result_next;
        end
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> design/olt_cell.sv
// one table slot: holds one order and passes the probe word to the next slot
// depends on olt_pkg
module olt_cell #(
    parameter logic [15:0] SLOT = 16'd0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  olt_pkg::probe_t  probe_in,
    input  olt_pkg::update_t upd,
    output olt_pkg::probe_t  probe_out
);
    import olt_pkg::*;

    logic        valid_reg;
    logic        active_reg;
    logic [31:0] ref_reg;
    logic [31:0] leaves_reg;
    probe_t      probe_reg;
    probe_t      probe_next;

    // fold this slot into the search word
    always_comb
    begin
        probe_next = probe_in;
        if (valid_reg && ref_reg == probe_in.user_ref && !probe_in.hit_user)
        begin
            probe_next.hit_user    = 1'b1;
            probe_next.slot_user   = SLOT;
            probe_next.leaves_user = leaves_reg;
        end
        if (valid_reg && ref_reg == probe_in.orig_ref && !probe_in.hit_orig)
        begin
            probe_next.hit_orig    = 1'b1;
            probe_next.slot_orig   = SLOT;
            probe_next.leaves_orig = leaves_reg;
        end
        if (!valid_reg && !probe_in.has_free)
        begin
            probe_next.has_free  = 1'b1;
            probe_next.slot_free = SLOT;
        end
    end

    // slot valid bit and probe stage marker
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= probe_in.active;
            if (upd.clr_all)
            begin
                valid_reg <= 1'b0;
            end
            else if (upd.en && upd.slot == SLOT)
            begin
                valid_reg <= upd.valid;
            end
        end
    end

    // payload without reset
    always_ff @(posedge clk)
    begin
        probe_reg <= probe_next;
        if (!upd.clr_all && upd.en && upd.slot == SLOT)
        begin
            ref_reg    <= upd.ref_val;
            leaves_reg <= upd.leaves;
        end
    end

    // outgoing probe word with the reset marker
    always_comb
    begin
        probe_out        = probe_reg;
        probe_out.active = active_reg;
    end

endmodule

>>> tb/tb_order_lifecycle_table.sv
// self-checking testbench for order_lifecycle_table: directed and random commands
// depends on olt_pkg and the order_lifecycle_table rtl; scores each result word
// against an in-bench table predictor
`timescale 1ns / 1ps

module tb_order_lifecycle_table;
    import olt_pkg::*;

    localparam int ENTRIES = 256;
    localparam int CMD_LAT = ENTRIES + 2;
    localparam longint CYCLE_LIMIT = 3000000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    order_t order;
    logic done;
    result_t result;
    logic cfg_we;
    logic cfg_index;
    logic [31:0] cfg_wdata;

    order_lifecycle_table #(.TABLE_ENTRIES(ENTRIES)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .order(order),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // predictor state
    logic [31:0] lim_qty;
    logic [31:0] lim_price;
    logic slot_live [ENTRIES];
    logic [31:0] slot_ref [ENTRIES];
    logic [31:0] slot_leaves [ENTRIES];
    logic [31:0] top_ref;
    logic [8:0] live_total;

    order_t pending_orders[$];
    result_t expected_results[$];
    int errors;
    longint cycles;
    int sender_idle_pct;
    logic hold_sender;
    logic [31:0] ref_cursor;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    endtask

    function automatic int find_order(input logic [31:0] r);
        for (int i = 0; i < ENTRIES; i++)
            if (slot_live[i] && slot_ref[i] == r) return i;
        return -1;
    endfunction

    // compute the result word of one command and update the table model
    function automatic result_t predict_lifecycle(input order_t o);
        result_t r;
        int s;
        int f;
        logic [31:0] old;
        r = '0;
        r.result_ref = o.user_ref;
        r.status = ST_REJECTED;
        if (o.cmd == CMD_ENTER || o.cmd == CMD_REPLACE)
        begin
            if (o.quantity == 0 || o.quantity > lim_qty) r.reason = RR_QUANTITY;
            else if (o.price == 0 || o.price > lim_price) r.reason = RR_PRICE;
            else if (!o.fields_ok) r.reason = RR_FIELDS;
            else if (o.cmd == CMD_ENTER)
            begin
                f = -1;
                for (int i = ENTRIES - 1; i >= 0; i--)
                    if (!slot_live[i]) f = i;
                if (find_order(o.user_ref) >= 0) r.reason = RR_DUPLICATE;
                else if (o.user_ref <= top_ref) r.reason = RR_STALE;
                else if (f < 0) r.reason = RR_FULL;
                else
                begin
                    slot_live[f] = 1'b1;
                    slot_ref[f] = o.user_ref;
                    slot_leaves[f] = o.quantity;
                    live_total++;
                    top_ref = o.user_ref;
                    r.status = ST_ACCEPTED;
                    r.leaves_qty = o.quantity;
                end
            end
            else
            begin
                s = find_order(o.orig_user_ref);
                if (s < 0) r.reason = RR_UNKNOWN;
                else if (find_order(o.user_ref) >= 0) r.reason = RR_DUPLICATE;
                else if (o.user_ref <= top_ref) r.reason = RR_STALE;
                else
                begin
                    r.dec_qty = slot_leaves[s];
                    slot_ref[s] = o.user_ref;
                    slot_leaves[s] = o.quantity;
                    top_ref = o.user_ref;
                    r.status = ST_REPLACED;
                    r.previous_ref = o.orig_user_ref;
                    r.leaves_qty = o.quantity;
                end
            end
        end
        else if (o.cmd == CMD_CANCEL)
        begin
            s = find_order(o.user_ref);
            if (!o.fields_ok) r.reason = RR_QUANTITY;
            else if (s < 0) r.reason = RR_UNKNOWN;
            else
            begin
                old = slot_leaves[s];
                if (o.quantity == 0 || o.quantity >= old)
                begin
                    slot_live[s] = 1'b0;
                    live_total--;
                    r.status = ST_CANCELED;
                    r.dec_qty = old;
                end
                else
                begin
                    slot_leaves[s] = old - o.quantity;
                    r.status = ST_PART_CANCELED;
                    r.dec_qty = o.quantity;
                    r.leaves_qty = old - o.quantity;
                end
            end
        end
        else if (o.cmd == CMD_EXECUTE)
        begin
            s = find_order(o.user_ref);
            if (o.quantity == 0 || o.quantity > lim_qty) r.reason = RR_QUANTITY;
            else if (s < 0) r.reason = RR_UNKNOWN;
            else if (o.quantity > slot_leaves[s]) r.reason = RR_OVERFILL;
            else
            begin
                slot_leaves[s] = slot_leaves[s] - o.quantity;
                r.dec_qty = o.quantity;
                r.leaves_qty = slot_leaves[s];
                if (slot_leaves[s] == 0)
                begin
                    slot_live[s] = 1'b0;
                    live_total--;
                    r.status = ST_FILLED;
                end
                else r.status = ST_PART_FILLED;
            end
        end
        else if (o.cmd == CMD_CLEAR)
        begin
            for (int i = 0; i < ENTRIES; i++) slot_live[i] = 1'b0;
            live_total = '0;
            top_ref = '0;
            r.status = ST_CLEARED;
            r.result_ref = '0;
        end
        else r.reason = RR_FIELDS;
        r.live_count = live_total;
        r.highest_ref = top_ref;
        return r;
    endfunction

    // driver: one command word per handshake, random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            order <= '0;
        end
        else if (start && !busy)
        begin
            start <= 1'b0;
        end
        else if (!start && !hold_sender && pending_orders.size() > 0
                 && $urandom_range(99) >= sender_idle_pct)
        begin
            order_t o;
            o = pending_orders.pop_front();
            expected_results.push_back(predict_lifecycle(o));
            order <= o;
            start <= 1'b1;
        end
    end

    // monitor: check each result word against the oldest expectation
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                report("unexpected result word", 32'd1, 32'd0);
            end
            else
            begin
                result_t w;
                w = expected_results.pop_front();
                if (result.status !== w.status)
                    report("status", 32'(result.status), 32'(w.status));
                if (result.reason !== w.reason)
                    report("reason", 32'(result.reason), 32'(w.reason));
                if (result.result_ref !== w.result_ref)
                    report("result_ref", result.result_ref, w.result_ref);
                if (result.previous_ref !== w.previous_ref)
                    report("previous_ref", result.previous_ref, w.previous_ref);
                if (result.dec_qty !== w.dec_qty)
                    report("decrement", result.dec_qty, w.dec_qty);
                if (result.leaves_qty !== w.leaves_qty)
                    report("leaves", result.leaves_qty, w.leaves_qty);
                if (result.live_count !== w.live_count)
                    report("live_count", 32'(result.live_count), 32'(w.live_count));
                if (result.highest_ref !== w.highest_ref)
                    report("highest_ref", result.highest_ref, w.highest_ref);
            end
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic order_t make_order(input logic [2:0] c, input logic [31:0] r,
                                          input logic [31:0] orig, input logic [31:0] q,
                                          input logic [31:0] p, input logic ok);
        order_t o;
        o.cmd = c;
        o.user_ref = r;
        o.orig_user_ref = orig;
        o.quantity = q;
        o.price = p;
        o.fields_ok = ok;
        return o;
    endfunction

    // a live-ish reference: mostly recent ones, sometimes anything
    function automatic logic [31:0] pick_ref();
        if ($urandom_range(9) == 0) return $urandom();
        if (ref_cursor < 40) return $urandom_range(ref_cursor + 1);
        return ref_cursor - $urandom_range(40);
    endfunction

    function automatic logic [31:0] pick_qty();
        case ($urandom_range(9))
            0: return 0;
            1: return $urandom();
            2: return lim_qty;
            3: return lim_qty + 1;
            default: return $urandom_range(200, 1);
        endcase
    endfunction

    // mostly well-formed lifecycle traffic, some noise
    function automatic order_t random_order();
        logic [31:0] p;
        int k;
        k = $urandom_range(99);
        p = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(5000, 1);
        if (k < 30)
        begin
            ref_cursor = ref_cursor + $urandom_range(3, 1);
            return make_order(CMD_ENTER, ref_cursor, $urandom(), pick_qty(), p,
                              $urandom_range(19) != 0);
        end
        if (k < 42)
        begin
            ref_cursor = ref_cursor + 1;
            return make_order(CMD_REPLACE, ($urandom_range(9) == 0) ? pick_ref() : ref_cursor,
                              pick_ref(), pick_qty(), p, $urandom_range(19) != 0);
        end
        if (k < 62)
            return make_order(CMD_CANCEL, pick_ref(), $urandom(),
                              $urandom_range(3) == 0 ? 0 : $urandom_range(150),
                              $urandom(), $urandom_range(19) != 0);
        if (k < 94)
            return make_order(CMD_EXECUTE, pick_ref(), $urandom(), pick_qty(), $urandom(),
                              $urandom_range(1) != 0);
        if (k < 96)
        begin
            ref_cursor = $urandom_range(100);
            return make_order(CMD_CLEAR, $urandom(), $urandom(), $urandom(), $urandom(),
                              $urandom_range(1) != 0);
        end
        if (k < 98)
            return make_order(3'($urandom_range(7, 5)), $urandom(), $urandom(), $urandom(),
                              $urandom(), $urandom_range(1) != 0);
        return make_order(3'($urandom_range(4)), $urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom_range(1) != 0);
    endfunction

    task automatic drain();
        while (pending_orders.size() > 0 || expected_results.size() > 0 || start)
            @(posedge clk);
        repeat (CMD_LAT + 4) @(posedge clk);
    endtask

    task automatic write_limit(input logic idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == REG_MAX_QUANTITY) lim_qty = val;
        else lim_price = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++) pending_orders.push_back(random_order());
        while (pending_orders.size() > 0) @(posedge clk);
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        hold_sender = 1'b0;
        sender_idle_pct = 31;
        lim_qty = 32'd1000000;
        lim_price = 32'd2000000000;
        for (int i = 0; i < ENTRIES; i++)
        begin
            slot_live[i] = 1'b0;
            slot_ref[i] = '0;
            slot_leaves[i] = '0;
        end
        top_ref = '0;
        live_total = '0;
        ref_cursor = 32'd10;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, every command and every reject reason but a full table
        pending_orders.push_back(make_order(CMD_ENTER, 5, 0, 0, 100, 1));
        pending_orders.push_back(make_order(CMD_ENTER, 5, 0, 32'd1000001, 100, 1));
        pending_orders.push_back(make_order(CMD_ENTER, 5, 0, 10, 0, 1));
        pending_orders.push_back(make_order(CMD_ENTER, 5, 0, 10, 32'd2000000001, 1));
        pending_orders.push_back(make_order(CMD_ENTER, 5, 0, 10, 100, 0));
        pending_orders.push_back(make_order(CMD_ENTER, 5, 0, 32'd1000000, 32'd2000000000, 1));
        pending_orders.push_back(make_order(CMD_ENTER, 5, 0, 10, 100, 1));
        pending_orders.push_back(make_order(CMD_ENTER, 3, 0, 10, 100, 1));
        pending_orders.push_back(make_order(CMD_ENTER, 8, 0, 1, 1, 1));
        pending_orders.push_back(make_order(CMD_REPLACE, 9, 77, 10, 100, 1));
        pending_orders.push_back(make_order(CMD_REPLACE, 8, 5, 10, 100, 1));
        pending_orders.push_back(make_order(CMD_REPLACE, 4, 5, 10, 100, 1));
        pending_orders.push_back(make_order(CMD_REPLACE, 12, 5, 50, 100, 1));
        pending_orders.push_back(make_order(CMD_CANCEL, 12, 0, 5, 0, 0));
        pending_orders.push_back(make_order(CMD_CANCEL, 99, 0, 5, 0, 1));
        pending_orders.push_back(make_order(CMD_CANCEL, 12, 0, 5, 0, 1));
        pending_orders.push_back(make_order(CMD_EXECUTE, 12, 0, 100, 0, 0));
        pending_orders.push_back(make_order(CMD_EXECUTE, 12, 0, 0, 0, 1));
        pending_orders.push_back(make_order(CMD_EXECUTE, 12, 0, 20, 0, 1));
        pending_orders.push_back(make_order(CMD_EXECUTE, 12, 0, 25, 0, 1));
        pending_orders.push_back(make_order(CMD_CANCEL, 8, 0, 0, 0, 1));
        pending_orders.push_back(make_order(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
        pending_orders.push_back(make_order(CMD_ENTER, 32'hFFFF_FFFF, 0, 1, 1, 1));
        pending_orders.push_back(make_order(CMD_CLEAR, 0, 0, 0, 0, 0));
        drain();

        // fill the table to overflow, then clear
        for (int i = 1; i <= ENTRIES + 2; i++)
            pending_orders.push_back(make_order(CMD_ENTER, i, 0, 1, 1, 1));
        pending_orders.push_back(make_order(CMD_CLEAR, 0, 0, 0, 0, 1));
        drain();

        // full-range limits, sender idles lightly
        write_limit(REG_MAX_QUANTITY, 32'hFFFF_FFFF);
        write_limit(REG_MAX_PRICE, 32'hFFFF_FFFF);
        ref_cursor = 32'd10;
        random_phase(280);

        // pause until all results are in, then tight limits, sender idles more
        hold_sender = 1'b1;
        drain();
        hold_sender = 1'b0;
        write_limit(REG_MAX_QUANTITY, 32'd1);
        write_limit(REG_MAX_PRICE, 32'd1);
        sender_idle_pct = 47;
        random_phase(150);
        drain();

        // moderate limits, no gaps
        write_limit(REG_MAX_QUANTITY, 32'd120);
        write_limit(REG_MAX_PRICE, 32'd3000);
        sender_idle_pct = 0;
        random_phase(330);
        drain();

        // reset defaults back, still no gaps
        write_limit(REG_MAX_QUANTITY, 32'd1000000);
        write_limit(REG_MAX_PRICE, 32'd2000000000);
        random_phase(110);
        drain();

        if (errors == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
